FILE: hw/rtl/ray_segment_intersection_defines.svh
// assertion helpers for the ray and segment intersection block
// all checks sample on clk and are held off while arst_n is low
`ifndef RAY_SEGMENT_INTERSECTION_DEFINES_SVH
`define RAY_SEGMENT_INTERSECTION_DEFINES_SVH

// condition must hold at every sampled edge
`define RSI_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define RSI_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RSI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/rsi_pkg.sv
`default_nettype none

package rsi_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int DIR_WIDTH   = 16;

	// segment and offset vectors
	localparam int DIFF_W   = COORD_WIDTH + 1;
	// direction times difference, and the denominator built from two of them
	localparam int DPROD_W  = DIR_WIDTH + DIFF_W;
	localparam int DEN_W    = DPROD_W + 1;
	localparam int DMAG_W   = DEN_W - 1;
	// difference times difference, and the ray numerator
	localparam int NPROD_W  = 2 * DIFF_W;
	localparam int NUMA_W   = NPROD_W + 1;
	localparam int MAG_W    = NUMA_W - 1;
	localparam int MAG_LO_W = MAG_W / 2;
	localparam int MAG_HI_W = MAG_W - MAG_LO_W;
	// scaled numerator and divider geometry
	localparam int PROD_W   = DIR_WIDTH + MAG_W;
	localparam int NUM_W    = PROD_W + 2;
	localparam int QUO_W    = COORD_WIDTH + 1;
	localparam int DIV_W    = DMAG_W + 1;
	localparam int TOP_W    = NUM_W - QUO_W;
	localparam int DIV_LAT  = QUO_W + 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIR_WIDTH-1:0]   dir_t;

	// classified request handed from the front to the back
	typedef struct packed {
		logic              hit;
		coord_t            ox;
		coord_t            oy;
		dir_t              rx;
		dir_t              ry;
		logic [MAG_W-1:0]  mag;
		logic [DMAG_W-1:0] dmag;
	} rsi_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rsi_qstat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rsi_front.sv
`default_nettype none

module rsi_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  rsi_pkg::coord_t       origin_x,
	input  rsi_pkg::coord_t       origin_y,
	input  rsi_pkg::dir_t         dir_x,
	input  rsi_pkg::dir_t         dir_y,
	input  rsi_pkg::coord_t       seg_start_x,
	input  rsi_pkg::coord_t       seg_start_y,
	input  rsi_pkg::coord_t       seg_end_x,
	input  rsi_pkg::coord_t       seg_end_y,
	input  rsi_pkg::rsi_qstat_t   qstat,
	output logic                  push,
	output rsi_pkg::rsi_item_t    item
);
	import rsi_pkg::*;

	typedef struct packed {
		coord_t ox;
		coord_t oy;
		dir_t   rx;
		dir_t   ry;
	} geo_t;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	geo_t geo_s1, geo_s2, geo_s3;
	logic signed [DIFF_W-1:0]  sx_s1, sy_s1, wx_s1, wy_s1;
	logic signed [DPROD_W-1:0] den_a_s2, den_b_s2, nb_a_s2, nb_b_s2;
	logic signed [NPROD_W-1:0] na_a_s2, na_b_s2;
	logic signed [DEN_W-1:0]   den_s3, numb_s3;
	logic signed [NUMA_W-1:0]  numa_s3;
	rsi_item_t                 item_s4;

	logic signed [DEN_W-1:0]  dabs, nb_n;
	logic signed [NUMA_W-1:0] aabs;
	logic                     den_neg, nega, zeroa, miss;

	assign en        = !(v_s4 && qstat.full);
	assign req_stall = !en;
	assign push      = v_s4 && en;
	assign item      = item_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// differences, then cross product terms, then their differences, then the classified item
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1 <= '{ox: origin_x, oy: origin_y, rx: dir_x, ry: dir_y};
			sx_s1  <= DIFF_W'(seg_end_x) - DIFF_W'(seg_start_x);
			sy_s1  <= DIFF_W'(seg_end_y) - DIFF_W'(seg_start_y);
			wx_s1  <= DIFF_W'(seg_start_x) - DIFF_W'(origin_x);
			wy_s1  <= DIFF_W'(seg_start_y) - DIFF_W'(origin_y);

			geo_s2   <= geo_s1;
			den_a_s2 <= DPROD_W'(geo_s1.rx) * DPROD_W'(sy_s1);
			den_b_s2 <= DPROD_W'(geo_s1.ry) * DPROD_W'(sx_s1);
			nb_a_s2  <= DPROD_W'(wx_s1) * DPROD_W'(geo_s1.ry);
			nb_b_s2  <= DPROD_W'(wy_s1) * DPROD_W'(geo_s1.rx);
			na_a_s2  <= NPROD_W'(wx_s1) * NPROD_W'(sy_s1);
			na_b_s2  <= NPROD_W'(wy_s1) * NPROD_W'(sx_s1);

			geo_s3  <= geo_s2;
			den_s3  <= DEN_W'(den_a_s2) - DEN_W'(den_b_s2);
			numb_s3 <= DEN_W'(nb_a_s2) - DEN_W'(nb_b_s2);
			numa_s3 <= NUMA_W'(na_a_s2) - NUMA_W'(na_b_s2);

			item_s4 <= '{hit: !miss, ox: geo_s3.ox, oy: geo_s3.oy, rx: geo_s3.rx,
				ry: geo_s3.ry, mag: aabs[MAG_W-1:0], dmag: dabs[DMAG_W-1:0]};
		end
	end

	// parallel, behind the origin, or off the segment
	always_comb begin
		den_neg = den_s3[DEN_W-1];
		nega    = numa_s3[NUMA_W-1];
		zeroa   = (numa_s3 == '0);
		dabs    = den_neg ? -den_s3 : den_s3;
		nb_n    = den_neg ? -numb_s3 : numb_s3;
		aabs    = nega ? -numa_s3 : numa_s3;
		miss    = (den_s3 == '0) || (!zeroa && (nega != den_neg)) ||
			nb_n[DEN_W-1] || (nb_n > dabs);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rsi_queue.sv
`default_nettype none

module rsi_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rsi_pkg::rsi_item_t  item_in,
	input  logic                pop,
	output rsi_pkg::rsi_item_t  head,
	output rsi_pkg::rsi_qstat_t qstat
);
	import rsi_pkg::*;

	rsi_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign head        = mem_q[rd_q];
	assign qstat.empty = (cnt_q == '0);
	assign qstat.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rsi_div.sv
`default_nettype none

module rsi_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rsi_pkg::NUM_W-1:0]  num,
	input  logic [rsi_pkg::DIV_W-1:0]  dv,
	output logic [rsi_pkg::QUO_W-1:0]  quo,
	output logic                       ovf
);
	import rsi_pkg::*;

	logic [DIV_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] low_s [QUO_W];
	logic [DIV_W-1:0] dv_s  [QUO_W];
	logic [QUO_W-1:0] quo_s [DIV_LAT];
	logic             ovf_s [DIV_LAT];

	logic [TOP_W-1:0] top;
	logic             over;

	// quotient too wide for its QUO_W bits: flag it, start from zero
	assign top  = num[NUM_W-1:QUO_W];
	assign over = (top >= TOP_W'(dv));

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= over ? '0 : top[DIV_W-1:0];
			low_s[0] <= num[QUO_W-1:0];
			dv_s[0]  <= dv;
			quo_s[0] <= '0;
			ovf_s[0] <= over;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		logic [DIV_W:0] trial, diff;
		logic           ge;

		assign trial = {rem_s[i], low_s[i][QUO_W-1]};
		assign ge    = (trial >= {1'b0, dv_s[i]});
		assign diff  = trial - {1'b0, dv_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[i+1] <= {quo_s[i][QUO_W-2:0], ge};
				ovf_s[i+1] <= ovf_s[i];
			end
		end

		if (i + 1 < QUO_W) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
					low_s[i+1] <= low_s[i] << 1;
					dv_s[i+1]  <= dv_s[i];
				end
			end
		end
	end

	assign quo = quo_s[QUO_W];
	assign ovf = ovf_s[QUO_W];

endmodule

`default_nettype wire

FILE: hw/rtl/rsi_back.sv
`default_nettype none

module rsi_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rsi_pkg::rsi_item_t  head,
	input  rsi_pkg::rsi_qstat_t qstat,
	output logic                pop,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic                hit,
	output rsi_pkg::coord_t     hit_x,
	output rsi_pkg::coord_t     hit_y,
	output logic                clipped
);
	import rsi_pkg::*;

	localparam int PLO_W = DIR_WIDTH + MAG_LO_W;
	localparam int PHI_W = DIR_WIDTH + MAG_HI_W;
	localparam int V_W   = QUO_W + 2;

	typedef struct packed {
		logic   hit;
		coord_t ox;
		coord_t oy;
		logic   negx;
		logic   negy;
	} side_t;

	logic en;
	logic vb_s1, vb_s2;
	logic vd_s [DIV_LAT];
	logic rsp_valid_q;

	side_t             side_s1, side_s2;
	side_t             side_d_s [DIV_LAT];
	logic [PLO_W-1:0]  plx_s1, ply_s1;
	logic [PHI_W-1:0]  phx_s1, phy_s1;
	logic [DMAG_W-1:0] dmag_s1;
	logic [NUM_W-1:0]  numx_s2, numy_s2;
	logic [DIV_W-1:0]  dv_s2;

	logic [DIR_WIDTH-1:0] mx, my;
	logic [PROD_W-1:0]    px, py;
	logic [QUO_W-1:0]     qx, qy;
	logic                 ovx, ovy;
	logic [COORD_WIDTH:0] resx, resy;
	side_t                last;

	logic   hit_q, clipped_q;
	coord_t hit_x_q, hit_y_q;

	// {clip, coordinate} for origin plus or minus the rounded offset
	function automatic logic [COORD_WIDTH:0] place(input coord_t org, input logic neg,
			input logic [QUO_W-1:0] q, input logic ovf);
		logic signed [V_W-1:0] v, hi, lo;
		logic [COORD_WIDTH:0]  r;
		hi = {{(V_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
		lo = {{(V_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
		v  = neg ? V_W'(org) - $signed({2'b00, q}) : V_W'(org) + $signed({2'b00, q});
		if (ovf) begin
			r = neg ? {1'b1, lo[COORD_WIDTH-1:0]} : {1'b1, hi[COORD_WIDTH-1:0]};
		end else if (v > hi) begin
			r = {1'b1, hi[COORD_WIDTH-1:0]};
		end else if (v < lo) begin
			r = {1'b1, lo[COORD_WIDTH-1:0]};
		end else begin
			r = {1'b0, v[COORD_WIDTH-1:0]};
		end
		return r;
	endfunction

	assign en  = !(rsp_valid_q && rsp_stall);
	assign pop = en && !qstat.empty;

	assign mx = head.rx[DIR_WIDTH-1] ? DIR_WIDTH'(-head.rx) : DIR_WIDTH'(head.rx);
	assign my = head.ry[DIR_WIDTH-1] ? DIR_WIDTH'(-head.ry) : DIR_WIDTH'(head.ry);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_s1       <= 1'b0;
			vb_s2       <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				vd_s[i] <= 1'b0;
			end
		end else if (en) begin
			vb_s1   <= !qstat.empty;
			vb_s2   <= vb_s1;
			vd_s[0] <= vb_s2;
			for (int i = 1; i < DIV_LAT; i++) begin
				vd_s[i] <= vd_s[i-1];
			end
			rsp_valid_q <= vd_s[DIV_LAT-1];
		end
	end

	// split products of |dir| and the numerator magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= '{hit: head.hit, ox: head.ox, oy: head.oy,
				negx: head.rx[DIR_WIDTH-1], negy: head.ry[DIR_WIDTH-1]};
			plx_s1  <= PLO_W'(mx) * PLO_W'(head.mag[MAG_LO_W-1:0]);
			ply_s1  <= PLO_W'(my) * PLO_W'(head.mag[MAG_LO_W-1:0]);
			phx_s1  <= PHI_W'(mx) * PHI_W'(head.mag[MAG_W-1:MAG_LO_W]);
			phy_s1  <= PHI_W'(my) * PHI_W'(head.mag[MAG_W-1:MAG_LO_W]);
			dmag_s1 <= head.dmag;

			side_s2 <= side_s1;
			numx_s2 <= {1'b0, px, 1'b0} + NUM_W'(dmag_s1);
			numy_s2 <= {1'b0, py, 1'b0} + NUM_W'(dmag_s1);
			dv_s2   <= {dmag_s1, 1'b0};

			side_d_s[0] <= side_s2;
			for (int i = 1; i < DIV_LAT; i++) begin
				side_d_s[i] <= side_d_s[i-1];
			end

			hit_q     <= last.hit;
			hit_x_q   <= last.hit ? resx[COORD_WIDTH-1:0] : '0;
			hit_y_q   <= last.hit ? resy[COORD_WIDTH-1:0] : '0;
			clipped_q <= last.hit && (resx[COORD_WIDTH] || resy[COORD_WIDTH]);
		end
	end

	// rounding numerator 2*m*mag + d over divisor 2*d
	assign px = (PROD_W'(phx_s1) << MAG_LO_W) + PROD_W'(plx_s1);
	assign py = (PROD_W'(phy_s1) << MAG_LO_W) + PROD_W'(ply_s1);

	rsi_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (numx_s2),
		.dv  (dv_s2),
		.quo (qx),
		.ovf (ovx)
	);

	rsi_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (numy_s2),
		.dv  (dv_s2),
		.quo (qy),
		.ovf (ovy)
	);

	assign last = side_d_s[DIV_LAT-1];
	assign resx = place(last.ox, last.negx, qx, ovx);
	assign resy = place(last.oy, last.negy, qy, ovy);

	assign rsp_valid = rsp_valid_q;
	assign hit       = hit_q;
	assign hit_x     = hit_x_q;
	assign hit_y     = hit_y_q;
	assign clipped   = clipped_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ray_segment_intersection.sv
// 2d ray against line segment test. each request carries a ray (origin in signed
// fixed point with 8 fraction bits, direction in signed q1.14) and a segment given
// by its two endpoints; the response says whether the ray meets the segment and,
// if so, where, with the point clamped to the coordinate range and clipped set
// when a clamp happened. parallel or degenerate inputs give no hit, and a miss
// returns zero coordinates. one request is taken every cycle while req_stall is low, and
// responses leave in request order; most of the pipeline is the two 25-stage restoring
// dividers in the back end, one quotient bit per stage. a four-entry queue sits between
// the classifying front end and the dividing back end so that each can stall on its own.
`default_nettype none
`include "ray_segment_intersection_defines.svh"

module ray_segment_intersection (
	input  logic            clk,
	input  logic            arst_n,
	// request channel
	input  logic            req_valid,
	output logic            req_stall,
	input  rsi_pkg::coord_t origin_x,
	input  rsi_pkg::coord_t origin_y,
	input  rsi_pkg::dir_t   dir_x,
	input  rsi_pkg::dir_t   dir_y,
	input  rsi_pkg::coord_t seg_start_x,
	input  rsi_pkg::coord_t seg_start_y,
	input  rsi_pkg::coord_t seg_end_x,
	input  rsi_pkg::coord_t seg_end_y,
	// response channel
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output logic            hit,
	output rsi_pkg::coord_t hit_x,
	output rsi_pkg::coord_t hit_y,
	output logic            clipped
);
	import rsi_pkg::*;

	// front to queue
	logic       q_push;
	rsi_item_t  q_in;
	// queue to back
	logic       q_pop;
	rsi_item_t  q_head;
	rsi_qstat_t qstat;

	// front end: edge vectors, cross products and the hit classification
	rsi_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.dir_x       (dir_x),
		.dir_y       (dir_y),
		.seg_start_x (seg_start_x),
		.seg_start_y (seg_start_y),
		.seg_end_x   (seg_end_x),
		.seg_end_y   (seg_end_y),
		.qstat       (qstat),
		.push        (q_push),
		.item        (q_in)
	);

	// decoupling queue, absorbs the back end's stall
	rsi_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.item_in (q_in),
		.pop     (q_pop),
		.head    (q_head),
		.qstat   (qstat)
	);

	// back end: scaled division for the ray parameter, then placement and clamping
	rsi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.qstat     (qstat),
		.pop       (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.hit       (hit),
		.hit_x     (hit_x),
		.hit_y     (hit_y),
		.clipped   (clipped)
	);

	// a miss carries zero coordinates and no clip
	`RSI_ASSERT_IMPLIES(a_miss_clean, rsp_valid && !hit, hit_x == '0 && hit_y == '0 && !clipped, "miss response carries data")
	// the front only holds requests back when the queue is full
	`RSI_ASSERT_IMPLIES(a_stall_full, req_stall, qstat.full, "request stalled with room in queue")
	// never write into a full queue
	`RSI_ASSERT_ALWAYS(a_push_room, !(q_push && qstat.full), "push into full queue")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rsi_pkg::*;

	localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
	localparam int DRAIN_CYCLES  = 80;    // settling time after the last response is checked
	localparam int WATCHDOG_MAX  = 3000;  // idle cycles tolerated on both channels
	localparam int RANDOM_ITEMS  = 1450;
	localparam longint OFF_CAP   = 64'sd1 << 62;

	// expected response of one request
	typedef struct {
		logic   hit;
		coord_t x;
		coord_t y;
		logic   clip;
	} crossing_t;

	// keeps the crossings still owed by the block, oldest first
	class crossing_board;
		crossing_t owed[$];
		int        errors;

		task report(string what);
			errors++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		// one coordinate of the hit point: origin plus rounded offset, clamped
		function coord_t place(longint org, longint d, longint mag, longint den,
				inout logic clip);
			logic [127:0] num;
			logic [127:0] quo;
			longint       off;
			longint       v;
			num = 128'(2) * 128'(d < 0 ? -d : d) * 128'(mag) + 128'(den);
			quo = num / (128'(2) * 128'(den));
			off = (quo > 128'(OFF_CAP)) ? OFF_CAP : longint'(quo);
			v   = (d < 0) ? org - off : org + off;
			if (v > longint'(coord_t'({1'b0, {(COORD_WIDTH-1){1'b1}}}))) begin
				clip = 1'b1;
				return {1'b0, {(COORD_WIDTH-1){1'b1}}};
			end
			if (v < longint'(coord_t'({1'b1, {(COORD_WIDTH-1){1'b0}}}))) begin
				clip = 1'b1;
				return {1'b1, {(COORD_WIDTH-1){1'b0}}};
			end
			return coord_t'(v);
		endfunction

		// note an accepted request and work out its crossing
		function void note(coord_t ox, coord_t oy, dir_t rx, dir_t ry,
				coord_t ax, coord_t ay, coord_t bx, coord_t by);
			crossing_t c;
			longint    sx, sy, wx, wy, den, numb, numa;
			sx   = longint'(bx) - longint'(ax);
			sy   = longint'(by) - longint'(ay);
			wx   = longint'(ax) - longint'(ox);
			wy   = longint'(ay) - longint'(oy);
			den  = longint'(rx) * sy - longint'(ry) * sx;
			numb = wx * longint'(ry) - wy * longint'(rx);
			numa = wx * sy - wy * sx;
			c = '{1'b0, '0, '0, 1'b0};
			// parallel, ray pointing away, or outside the segment: all a miss
			if (den != 0 && !(numa != 0 && ((numa < 0) != (den < 0)))) begin
				if (den < 0) begin
					den  = -den;
					numb = -numb;
				end
				if (numb >= 0 && numb <= den) begin
					c.hit = 1'b1;
					c.x = place(longint'(ox), longint'(rx), numa < 0 ? -numa : numa, den, c.clip);
					c.y = place(longint'(oy), longint'(ry), numa < 0 ? -numa : numa, den, c.clip);
				end
			end
			owed.insert(owed.size(), c);
		endfunction

		// compare one accepted response with the oldest crossing owed
		task check(logic h, coord_t x, coord_t y, logic cl);
			crossing_t c;
			if (owed.size() == 0) begin
				report("response with no request outstanding");
				return;
			end
			c = owed.pop_front();
			if (h !== c.hit)
				report($sformatf("hit %b, expected %b", h, c.hit));
			if (x !== c.x)
				report($sformatf("hit_x %0d, expected %0d", x, c.x));
			if (y !== c.y)
				report($sformatf("hit_y %0d, expected %0d", y, c.y));
			if (cl !== c.clip)
				report($sformatf("clipped %b, expected %b", cl, c.clip));
		endtask
	endclass

	logic   clk;
	logic   arst_n;
	logic   req_valid;
	logic   req_stall;
	coord_t origin_x, origin_y;
	dir_t   dir_x, dir_y;
	coord_t seg_start_x, seg_start_y, seg_end_x, seg_end_y;
	logic   rsp_valid;
	logic   rsp_stall;
	logic   hit;
	coord_t hit_x, hit_y;
	logic   clipped;

	crossing_board board;
	bit            hold_request;   // asks the receiver for one long hold-off
	bit            calm;           // stretch with no idling on either side
	int            idle_cycles;

	ray_segment_intersection i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.origin_x(origin_x), .origin_y(origin_y),
		.dir_x(dir_x), .dir_y(dir_y),
		.seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
		.seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.hit(hit), .hit_x(hit_x), .hit_y(hit_y), .clipped(clipped)
	);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// gap length: mostly none or short, now and then long
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one request from the falling edge and hold it until it is taken
	task send_req(coord_t ox, coord_t oy, dir_t rx, dir_t ry,
			coord_t ax, coord_t ay, coord_t bx, coord_t by);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid   = 1'b1;
		origin_x    = ox;
		origin_y    = oy;
		dir_x       = rx;
		dir_y       = ry;
		seg_start_x = ax;
		seg_start_y = ay;
		seg_end_x   = bx;
		seg_end_y   = by;
		do
			@(posedge clk);
		while (req_stall);
		board.note(ox, oy, rx, ry, ax, ay, bx, by);
		@(negedge clk);
	endtask

	// random value within +/- 2^bits, as a coordinate
	function coord_t near(int bits);
		return coord_t'(longint'($urandom_range(0, (1 << (bits + 1)) - 1)) - (longint'(1) << bits));
	endfunction

	// ray aimed at a point on a random segment, so most of these hit
	task send_aimed();
		coord_t ax, ay, bx, by, ox, oy;
		longint px, py, dx, dy;
		int     k;
		ax = near(16);
		ay = near(16);
		bx = near(16);
		by = near(16);
		ox = near(16);
		oy = near(16);
		k  = $urandom_range(0, 16);
		px = longint'(ax) + (longint'(bx) - longint'(ax)) * k / 16;
		py = longint'(ay) + (longint'(by) - longint'(ay)) * k / 16;
		dx = px - longint'(ox);
		dy = py - longint'(oy);
		while (dx > 32767 || dx < -32768 || dy > 32767 || dy < -32768) begin
			dx = dx / 2;
			dy = dy / 2;
		end
		send_req(ox, oy, dir_t'(dx), dir_t'(dy), ax, ay, bx, by);
	endtask

	// receiver stall, with one long hold-off on request
	always @(negedge clk) begin
		if (hold_request) begin
			rsp_stall = 1'b1;
			repeat (HOLD_CYCLES - 1) @(negedge clk);
			hold_request = 1'b0;
		end else if (calm)
			rsp_stall = 1'b0;
		else
			rsp_stall = ($urandom_range(0, 99) < 30);
	end

	// switch between calm and busy stretches
	always begin
		repeat ($urandom_range(100, 300)) @(negedge clk);
		calm = ($urandom_range(0, 3) == 0);
	end

	// response checking at the rising edge
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			board.check(hit, hit_x, hit_y, clipped);
	end

	// watchdog on cycles with no traffic on either side
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int r;
		board        = new();
		hold_request = 1'b0;
		calm         = 1'b0;
		idle_cycles  = 0;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		rsp_stall    = 1'b0;
		origin_x     = '0;
		origin_y     = '0;
		dir_x        = '0;
		dir_y        = '0;
		seg_start_x  = '0;
		seg_start_y  = '0;
		seg_end_x    = '0;
		seg_end_y    = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// plain hit straight ahead
		send_req(0, 0, 16384, 0, 2560, -256, 2560, 256);
		// parallel lines
		send_req(0, 0, 16384, 0, 256, 512, 2560, 512);
		// zero direction
		send_req(0, 0, 0, 0, 2560, -256, 2560, 256);
		// zero-length segment
		send_req(0, 0, 16384, 0, 2560, 0, 2560, 0);
		// touching the first and the second endpoint
		send_req(0, 0, 16384, 0, 2560, 0, 2560, 256);
		send_req(0, 0, 16384, 0, 2560, -256, 2560, 0);
		// origin on the segment
		send_req(0, 0, 16384, 16384, -256, 256, 256, -256);
		// segment behind the ray
		send_req(0, 0, 16384, 0, -2560, -256, -2560, 256);
		// vertical ray, up and down
		send_req(0, 0, 0, 16384, -256, 1280, 256, 1280);
		send_req(0, 0, 0, -16384, -256, -1280, 256, -1280);
		// offset exactly halfway between two steps, both signs
		send_req(0, 0, 2, 1, 3, -256, 3, 256);
		send_req(0, 0, 2, -1, 3, -256, 3, 256);
		// segment outside its span on the far side
		send_req(0, 0, 16384, 0, 2560, 256, 2560, 512);
		// coordinate and direction extremes
		send_req(24'sh800000, 24'sh800000, 16'sh7fff, 16'sh7fff,
			24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff);
		send_req(24'sh7fffff, 24'sh7fffff, 16'sh8000, 16'sh8000,
			24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh800000);
		send_req(24'sh800000, 0, 16'sh7fff, 0, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh7fffff);
		send_req(24'sh7fffff, 0, 16'sh8000, 0, 24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh800000);
		send_req(0, 24'sh800000, 0, 16'sh7fff, 24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
		send_req(24'sh7fffff, 24'sh7fffff, 16'sh7fff, 16'sh7fff,
			24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
		send_req(24'sh800000, 24'sh800000, 16'sh8000, 16'sh8000,
			24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// one long receiver hold-off while requests keep coming
			if (n == 500)
				hold_request = 1'b1;
			// one pause until every response is back
			if (n == 1000) begin
				req_valid = 1'b0;
				while (board.owed.size() != 0) @(negedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 45)
				send_aimed();
			else if (r < 70)
				send_req(near(12), near(12), dir_t'($urandom), dir_t'($urandom),
					near(12), near(12), near(12), near(12));
			else if (r < 90)
				send_req(coord_t'($urandom), coord_t'($urandom), dir_t'($urandom),
					dir_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), coord_t'($urandom));
			else begin
				// parallel to the ray, or a degenerate segment
				coord_t ax, ay;
				dir_t   rx, ry;
				int     k;
				ax = near(16);
				ay = near(16);
				rx = dir_t'(int'($urandom_range(0, 511)) - 256);
				ry = dir_t'(int'($urandom_range(0, 511)) - 256);
				k  = $urandom_range(0, 8);
				send_req(near(16), near(16), rx, ry, ax, ay,
					coord_t'(longint'(ax) + longint'(rx) * k),
					coord_t'(longint'(ay) + longint'(ry) * k));
			end
		end
		req_valid = 1'b0;

		while (board.owed.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
